### sv/bgc_pkg.sv
// Package for the push-button gesture classifier.
// Holds edge and gesture codes, register indexes, reset values and the config struct.
// No dependencies.
package bgc_pkg;

    // Last edge seen on the pin
    typedef enum logic [1:0] {
        EDGE_FALL = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_NONE = 2'd2
    } t_edge;

    // Reported gesture codes
    typedef enum logic [2:0] {
        G_NONE       = 3'd0,
        G_SINGLE     = 3'd1,
        G_DOUBLE     = 3'd2,
        G_TRIPLE     = 3'd3,
        G_SHORT_TAP  = 3'd4,
        G_LONG_TAP   = 3'd5,
        G_LONG_PRESS = 3'd6
    } t_gesture;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TAP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TAP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COOLDOWN    = 3'd4;

    // Register values after reset
    localparam logic [15:0] RST_RELEASE_TIMEOUT = 16'd500;
    localparam logic [15:0] RST_LONG_PRESS      = 16'd2000;
    localparam logic [7:0]  RST_SHORT_TAP_LIMIT = 8'd4;
    localparam logic [7:0]  RST_LONG_TAP_LIMIT  = 8'd8;
    localparam logic [15:0] RST_TAP_COOLDOWN    = 16'd1000;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Configuration as seen by the classifier core
    typedef struct packed {
        logic [15:0] release_timeout_ms;
        logic [15:0] long_press_ms;
        logic [7:0]  short_tap_limit;
        logic [7:0]  long_tap_limit;
        logic [15:0] tap_cooldown_ms;
    } t_cfg;

endpackage

### sv/bgc_core.sv
// Classifier core: edge detection, press counting and gesture decision for one sample.
// Holds the gesture state; result is combinational from the sample and state.
// Depends on bgc_pkg.
module bgc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [31:0]       i_now,
    input  bgc_pkg::t_cfg     i_cfg,
    output bgc_pkg::t_gesture o_gesture
);
    import bgc_pkg::*;

    logic        r_prev_level;
    t_edge       r_edge;
    logic [7:0]  r_press_count;
    logic [31:0] r_press_stamp;
    logic [31:0] r_release_stamp;
    logic [31:0] r_short_tap_stamp;
    logic [31:0] r_long_tap_stamp;

    logic        fall;
    logic        rise;
    t_edge       edge_cur;
    logic [7:0]  count_cur;
    logic [31:0] press_stamp_cur;
    logic [31:0] release_stamp_cur;
    logic [31:0] dt_release;
    logic [31:0] dt_press;
    logic [31:0] dt_long_tap;
    logic [31:0] dt_short_tap;
    logic        rel_hit;
    logic        lp_hit;
    logic        lt_hit;
    logic        st_hit;
    logic        clear;
    t_gesture    clicks;

    // Edge detection and state as updated by this sample
    always_comb begin
        fall = (i_level != r_prev_level) && !i_level;
        rise = (i_level != r_prev_level) && i_level;
        edge_cur = fall ? EDGE_FALL : (rise ? EDGE_RISE : r_edge);
        count_cur = (fall && (r_press_count != COUNT_MAX)) ? r_press_count + 8'd1
                                                           : r_press_count;
        press_stamp_cur = fall ? i_now : r_press_stamp;
        release_stamp_cur = rise ? i_now : r_release_stamp;
    end

    // Wrapped time differences and threshold checks
    always_comb begin
        dt_release   = i_now - release_stamp_cur;
        dt_press     = i_now - press_stamp_cur;
        dt_long_tap  = i_now - r_long_tap_stamp;
        dt_short_tap = i_now - r_short_tap_stamp;
        rel_hit = (edge_cur == EDGE_RISE) && (dt_release > {16'd0, i_cfg.release_timeout_ms});
        lp_hit  = (edge_cur == EDGE_FALL) && (dt_press > {16'd0, i_cfg.long_press_ms});
        lt_hit  = (count_cur > i_cfg.long_tap_limit)
                  && (dt_long_tap > {16'd0, i_cfg.tap_cooldown_ms});
        st_hit  = (count_cur > i_cfg.short_tap_limit)
                  && (dt_short_tap > {16'd0, i_cfg.tap_cooldown_ms});
    end

    // Map the press count to a click gesture
    always_comb begin
        unique case (count_cur)
            8'd1:    clicks = G_SINGLE;
            8'd2:    clicks = G_DOUBLE;
            8'd3:    clicks = G_TRIPLE;
            default: clicks = G_NONE;
        endcase
    end

    // Pick one gesture: release, long press, long tap, short tap
    always_comb begin
        clear = 1'b0;
        priority if (rel_hit) begin
            o_gesture = clicks;
            clear = 1'b1;
        end else if (lp_hit) begin
            o_gesture = G_LONG_PRESS;
            clear = 1'b1;
        end else if (lt_hit) begin
            o_gesture = G_LONG_TAP;
        end else if (st_hit) begin
            o_gesture = G_SHORT_TAP;
        end else begin
            o_gesture = G_NONE;
        end
    end

    // Commit state on each sample taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level      <= 1'b0;
            r_edge            <= EDGE_NONE;
            r_press_count     <= 8'd0;
            r_press_stamp     <= 32'd0;
            r_release_stamp   <= 32'd0;
            r_short_tap_stamp <= 32'd0;
            r_long_tap_stamp  <= 32'd0;
        end else if (i_step) begin
            r_prev_level    <= i_level;
            r_press_stamp   <= press_stamp_cur;
            r_release_stamp <= release_stamp_cur;
            r_edge          <= clear ? EDGE_NONE : edge_cur;
            r_press_count   <= clear ? 8'd0 : count_cur;
            if (!rel_hit && !lp_hit && lt_hit) begin
                r_long_tap_stamp <= i_now;
            end
            if (!rel_hit && !lp_hit && !lt_hit && st_hit) begin
                r_short_tap_stamp <= i_now;
            end
        end
    end

    // Resolving or long press clears the count and edge memory
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (rel_hit || lp_hit) |=> (r_press_count == 8'd0) && (r_edge == EDGE_NONE))
        else $error("count not cleared after resolve");

    // A long tap restamps its cooldown
    a_lt_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_gesture == G_LONG_TAP) |=> r_long_tap_stamp == $past(i_now))
        else $error("long tap stamp not updated");

    // State holds between samples
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_press_count) && $stable(r_edge) && $stable(r_prev_level))
        else $error("state changed without a sample");

endmodule

### sv/button_gesture_classifier_top.sv
// A sample accepted into the input register passes through bgc_core into the result register, then shows on m_axis.
// Throughput: one sample per cycle while m_axis is not stalled; the input and result registers advance together.
// Reset (i_rst_n low, synchronous): pipeline empty, gesture state cleared, registers at defaults.
// Config writes are always ready and apply at once; write only while the block is idle.
// Top level of the push-button gesture classifier; depends on bgc_pkg and bgc_core.
module button_gesture_classifier_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // [0] button_level, [32:1] now_ms
    // Gesture stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [2:0] gesture
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bgc_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_level;
    logic [31:0] r_in_now;
    logic        r_out_valid;
    t_gesture    r_out_gesture;
    t_gesture    gesture;
    logic        advance;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_timeout_ms <= RST_RELEASE_TIMEOUT;
            r_cfg.long_press_ms      <= RST_LONG_PRESS;
            r_cfg.short_tap_limit    <= RST_SHORT_TAP_LIMIT;
            r_cfg.long_tap_limit     <= RST_LONG_TAP_LIMIT;
            r_cfg.tap_cooldown_ms    <= RST_TAP_COOLDOWN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RELEASE_TIMEOUT: r_cfg.release_timeout_ms <= i_cfg_data;
                REG_LONG_PRESS:      r_cfg.long_press_ms      <= i_cfg_data;
                REG_SHORT_TAP_LIMIT: r_cfg.short_tap_limit    <= i_cfg_data[7:0];
                REG_LONG_TAP_LIMIT:  r_cfg.long_tap_limit     <= i_cfg_data[7:0];
                REG_TAP_COOLDOWN:    r_cfg.tap_cooldown_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a held request when the result slot is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[32:1];
        end
    end

    bgc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_level   (r_in_level),
        .i_now     (r_in_now),
        .i_cfg     (r_cfg),
        .o_gesture (gesture)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_gesture <= gesture;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_gesture};

    // A result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !advance)
        else $error("result overwritten while stalled");

    // A held request moves on whenever the output side can take it
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (!r_out_valid || m_axis_tready) |=> r_out_valid)
        else $error("result not produced");

    // Gesture codes stay within the defined set
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_gesture != 3'd7)
        else $error("invalid gesture code");

endmodule

### tb/gesture_checker.sv
// Gesture checker: watches the sample, gesture and configuration channels of the classifier.
// Keeps its own copy of the classifier state, predicts each gesture and compares in order.
// Depends on bgc_pkg.
module gesture_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic                           i_s_ready,
    input  logic [39:0]                    i_s_data,    // [0] button_level, [32:1] now_ms
    input  logic                           i_m_valid,
    input  logic                           i_m_ready,
    input  logic [7:0]                     i_m_data,    // [2:0] gesture
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned                    o_mismatches,
    output int unsigned                    o_pending,
    output int unsigned                    o_accepted,
    output int unsigned                    o_gestures,
    output int unsigned                    o_cfg_writes
);
    import bgc_pkg::*;

    // Predicted classifier state and settings
    t_cfg        cfg;
    logic        last_level;
    t_edge       last_edge;
    logic [7:0]  presses;
    logic [31:0] press_time;
    logic [31:0] release_time;
    logic [31:0] short_tap_time;
    logic [31:0] long_tap_time;

    t_gesture    expected_gestures[$];
    t_gesture    want;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned accepted = 0;
    int unsigned gestures = 0;
    int unsigned cfg_writes = 0;

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        mismatches++;
        $display("gesture_checker: %s at result %0d: expected %0d, got %0d",
                 what, results_seen, want_v, got_v);
    endtask

    // Advance the predicted state by one pin request and return the gesture it yields
    function automatic t_gesture classify_sample(input logic level, input logic [31:0] now);
        logic     fell;
        logic     rose;
        t_gesture clicks;
        fell = (level != last_level) && !level;
        rose = (level != last_level) && level;
        if (fell) last_edge = EDGE_FALL;
        if (rose) last_edge = EDGE_RISE;
        last_level = level;
        if (fell) begin
            if (presses != COUNT_MAX) presses = presses + 8'd1;
            press_time = now;
        end
        if (rose) release_time = now;

        // Released long enough: resolve the click count and clear
        if (last_edge == EDGE_RISE && (now - release_time) > {16'd0, cfg.release_timeout_ms}) begin
            case (presses)
                8'd1:    clicks = G_SINGLE;
                8'd2:    clicks = G_DOUBLE;
                8'd3:    clicks = G_TRIPLE;
                default: clicks = G_NONE;
            endcase
            presses   = '0;
            last_edge = EDGE_NONE;
            return clicks;
        end
        // Held long enough: long press and clear
        if (last_edge == EDGE_FALL && (now - press_time) > {16'd0, cfg.long_press_ms}) begin
            presses   = '0;
            last_edge = EDGE_NONE;
            return G_LONG_PRESS;
        end
        // Tap events, each held back by its own cooldown
        if (presses > cfg.long_tap_limit && (now - long_tap_time) > {16'd0, cfg.tap_cooldown_ms})
        begin
            long_tap_time = now;
            return G_LONG_TAP;
        end
        if (presses > cfg.short_tap_limit &&
            (now - short_tap_time) > {16'd0, cfg.tap_cooldown_ms}) begin
            short_tap_time = now;
            return G_SHORT_TAP;
        end
        return G_NONE;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.release_timeout_ms = RST_RELEASE_TIMEOUT;
            cfg.long_press_ms      = RST_LONG_PRESS;
            cfg.short_tap_limit    = RST_SHORT_TAP_LIMIT;
            cfg.long_tap_limit     = RST_LONG_TAP_LIMIT;
            cfg.tap_cooldown_ms    = RST_TAP_COOLDOWN;
            last_level     = 1'b0;
            last_edge      = EDGE_NONE;
            presses        = '0;
            press_time     = '0;
            release_time   = '0;
            short_tap_time = '0;
            long_tap_time  = '0;
            expected_gestures.delete();
        end else begin
            // Compare each gesture request with the oldest prediction
            if (i_m_valid && i_m_ready) begin
                results_seen++;
                if (expected_gestures.size() == 0) begin
                    report_mismatch("gesture with none predicted", 0, 32'(i_m_data));
                end else begin
                    want = expected_gestures.pop_front();
                    if (i_m_data[2:0] != want)
                        report_mismatch("gesture", 32'(want), 32'(i_m_data[2:0]));
                    if (i_m_data[7:3] != '0)
                        report_mismatch("tdata padding", 0, 32'(i_m_data[7:3]));
                end
            end
            // Predict the gesture for each accepted pin request
            if (i_s_valid && i_s_ready) begin
                want = classify_sample(i_s_data[0], i_s_data[32:1]);
                expected_gestures.push_back(want);
                accepted++;
                if (want != G_NONE) gestures++;
            end
            // Track register writes; unused indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    REG_RELEASE_TIMEOUT: cfg.release_timeout_ms = i_cfg_data;
                    REG_LONG_PRESS:      cfg.long_press_ms      = i_cfg_data;
                    REG_SHORT_TAP_LIMIT: cfg.short_tap_limit    = i_cfg_data[7:0];
                    REG_LONG_TAP_LIMIT:  cfg.long_tap_limit     = i_cfg_data[7:0];
                    REG_TAP_COOLDOWN:    cfg.tap_cooldown_ms    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= 32'(expected_gestures.size());
        o_accepted   <= accepted;
        o_gestures   <= gestures;
        o_cfg_writes <= cfg_writes;
    end

endmodule

### tb/tb.sv
// Testbench top for the push-button gesture classifier: clock, reset, pin and register stimulus.
// Depends on bgc_pkg, button_gesture_classifier_top and gesture_checker.
module tb;
    import bgc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned CHOKE_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned SETTINGS_RUN = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_TAP_COOLDOWN + 3'd1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned accepted;
    int unsigned gestures;
    int unsigned cfg_writes;

    // Stimulus state: current pin time and the settings the block holds
    logic [31:0] stamp        = '0;
    int unsigned rel_to       = 32'(RST_RELEASE_TIMEOUT);
    int unsigned hold_to      = 32'(RST_LONG_PRESS);
    int unsigned short_cnt    = 32'(RST_SHORT_TAP_LIMIT);
    int unsigned samples_sent = 0;
    int unsigned cycles       = 0;
    int unsigned choke_req    = 0;
    int unsigned choke_done   = 0;
    bit          src_steady   = 1'b0;
    bit          sink_steady  = 1'b0;

    button_gesture_classifier_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gesture_checker u_gesture_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_accepted   (accepted),
        .o_gestures   (gestures),
        .o_cfg_writes (cfg_writes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Gesture sink: random stalls, steady stretches, and a long hold-off on request
    initial begin : gesture_sink
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (choke_done != choke_req) begin
                m_axis_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
                choke_done = choke_req;
            end
            if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Offer one pin request at the current stamp; valid stays high for a back-to-back request
    task automatic send_sample(input logic level);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, stamp, level};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    task automatic sample_at(input logic level, input logic [31:0] t);
        stamp = t;
        send_sample(level);
    endtask

    task automatic step_time(input int unsigned lim);
        stamp += $urandom_range(0, lim);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Wait until every predicted gesture has come back, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || accepted != samples_sent);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers; count registers carry junk in their upper byte, plus a stray index
    task automatic apply_settings(input int unsigned rt, input int unsigned lp,
                                  input int unsigned stc, input int unsigned ltc,
                                  input int unsigned cd);
        cfg_write(REG_RELEASE_TIMEOUT, 16'(rt));
        cfg_write(REG_LONG_PRESS, 16'(lp));
        cfg_write(REG_SHORT_TAP_LIMIT, {8'($urandom_range(0, 255)), 8'(stc)});
        cfg_write(REG_LONG_TAP_LIMIT, {8'($urandom_range(0, 255)), 8'(ltc)});
        cfg_write(REG_TAP_COOLDOWN, 16'(cd));
        cfg_write(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        rel_to    = rt;
        hold_to   = lp;
        short_cnt = stc;
    endtask

    // Presses and releases inside both timeouts, then a release long enough to resolve
    task automatic play_clicks(input int unsigned count);
        repeat (count) begin
            step_time(rel_to / 4);
            send_sample(1'b0);
            repeat ($urandom_range(0, 2)) begin
                step_time(hold_to / 4);
                send_sample(1'b0);
            end
            step_time(hold_to / 4);
            send_sample(1'b1);
            repeat ($urandom_range(0, 2)) begin
                step_time(rel_to / 4);
                send_sample(1'b1);
            end
        end
        stamp += rel_to + $urandom_range(1, 64);
        send_sample(1'b1);
    endtask

    task automatic play_long_press();
        step_time(rel_to / 4);
        send_sample(1'b0);
        repeat ($urandom_range(0, 2)) begin
            step_time(hold_to / 4);
            send_sample(1'b0);
        end
        stamp += hold_to + $urandom_range(1, 64);
        send_sample(1'b0);
        step_time(rel_to / 4);
        send_sample(1'b1);
        stamp += rel_to + $urandom_range(1, 64);
        send_sample(1'b1);
    endtask

    // Rapid presses that pile up the count past the tap thresholds
    task automatic play_taps(input int unsigned count);
        int unsigned lim;
        lim = ((rel_to < hold_to) ? rel_to : hold_to) / 4;
        if (lim == 0) lim = 2;
        repeat (count) begin
            step_time(lim);
            send_sample(1'b0);
            step_time(lim);
            send_sample(1'b1);
        end
        stamp += rel_to + $urandom_range(1, 64);
        send_sample(1'b1);
    endtask

    // Arbitrary levels and time jumps, wraps included
    task automatic play_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0:       stamp = $urandom;
                1:       step_time(65535);
                default: step_time(2 * rel_to + 1);
            endcase
            send_sample(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        int unsigned taps;
        stop_at = samples_sent + quota;
        // Hold off the sink while requests keep coming so the block backs up
        choke_req++;
        while (samples_sent < stop_at) begin
            src_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: play_clicks($urandom_range(1, 3));
                3:       play_clicks($urandom_range(4, 6));
                4, 5:    play_long_press();
                6, 7: begin
                    taps = short_cnt + $urandom_range(1, 12);
                    play_taps((taps > 40) ? $urandom_range(20, 40) : taps);
                end
                default: play_noise();
            endcase
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at reset settings
        sample_at(1'b1, 32'd0);              // released first sample reads as a rising edge
        sample_at(1'b1, 32'd501);            // resolve with nothing counted
        sample_at(1'b0, 32'd1000);           // single click, timeout edge exactly equal first
        sample_at(1'b1, 32'd1100);
        sample_at(1'b1, 32'd1600);
        sample_at(1'b1, 32'd1601);
        sample_at(1'b0, 32'd2000);           // double click
        sample_at(1'b1, 32'd2050);
        sample_at(1'b0, 32'd2100);
        sample_at(1'b1, 32'd2150);
        sample_at(1'b1, 32'd2651);
        sample_at(1'b0, 32'd3000);           // triple click
        sample_at(1'b1, 32'd3010);
        sample_at(1'b0, 32'd3020);
        sample_at(1'b1, 32'd3030);
        sample_at(1'b0, 32'd3040);
        sample_at(1'b1, 32'd3050);
        sample_at(1'b1, 32'd3551);
        sample_at(1'b0, 32'hFFFF_FC00);      // long press held across the time wrap
        sample_at(1'b0, 32'hFFFF_FFFF);
        sample_at(1'b0, 32'h0000_0500);
        sample_at(1'b1, 32'h0000_0501);
        settle();

        // Random traffic under several settings, extremes included
        apply_settings(32'(RST_RELEASE_TIMEOUT), 32'(RST_LONG_PRESS),
                       32'(RST_SHORT_TAP_LIMIT), 32'(RST_LONG_TAP_LIMIT),
                       32'(RST_TAP_COOLDOWN));
        run_random(250);
        settle();

        apply_settings(0, 0, 0, 0, 0);
        run_random(150);
        settle();

        stamp = 32'hFFFF_0000;
        apply_settings(65535, 65535, 255, 255, 65535);
        run_random(150);
        settle();

        // Small thresholds, with one burst that saturates the press count
        apply_settings(100, 300, 2, 4, 50);
        src_steady = 1'b0;
        play_taps(260);
        run_random(150);
        settle();

        repeat (2) begin
            apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 20), $urandom_range(0, 20),
                           $urandom_range(0, 65535));
            run_random(250);
            settle();
        end

        $display("tb: %0d pin requests over %0d settings, %0d register writes", accepted,
                 SETTINGS_RUN, cfg_writes);
        $display("tb: %0d gestures other than none, %0d mismatches", gestures, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
